@@ design/beq_pkg.sv @@
// ----------------------------------------------------------------------------
// beq_pkg: shared types and constants of the three-band biquad equalizer
// Coefficient formats, history layout, item structs and memory request group.
// ----------------------------------------------------------------------------
package beq_pkg;

  // filter dimensions
  localparam int NUM_BANDS    = 3;
  localparam int NUM_CHANNELS = 2;
  localparam int COEF_WIDTH   = 21;
  localparam int SAMPLE_WIDTH = 24;

  // derived widths
  localparam int CHAN_W     = 3;
  localparam int HIST_W     = 32;
  localparam int COEF_FRAC  = COEF_WIDTH - 4;
  localparam int NUM_REGS   = 2 * NUM_BANDS;
  localparam int FWD_W      = 3 * COEF_WIDTH;
  localparam int FB_W       = 2 * COEF_WIDTH;
  localparam int CFG_DATA_W = FWD_W;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int HIST_DEPTH = NUM_BANDS * NUM_CHANNELS;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int BAND_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int SLOT_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PROD_W     = COEF_WIDTH + HIST_W;
  localparam int ACC_W      = PROD_W + 3;

  // input item
  typedef struct packed {
    logic [CHAN_W-1:0]              channel;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [CHAN_W-1:0]              out_channel;
    logic signed [SAMPLE_WIDTH-1:0] out_sample;
    logic                           clipped;
  } out_item_t;

  // one history entry: two past inputs and two past outputs of a section
  typedef struct packed {
    logic signed [HIST_W-1:0] y2;
    logic signed [HIST_W-1:0] y1;
    logic signed [HIST_W-1:0] x2;
    logic signed [HIST_W-1:0] x1;
  } hist_entry_t;

  // history memory access group
  typedef struct packed {
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;
    logic               wr_en;
    logic [HIST_AW-1:0] wr_addr;
  } hist_req_t;

endpackage

@@ design/beq_hist_mem.sv @@
// ----------------------------------------------------------------------------
// beq_hist_mem: section history memory
// One entry per band and channel slot, registered read, one read and one
// write port. Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module beq_hist_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  beq_pkg::hist_req_t  req_i,
  input  beq_pkg::hist_entry_t wr_data_i,
  output beq_pkg::hist_entry_t rd_data_o
);

  beq_pkg::hist_entry_t mem [beq_pkg::HIST_DEPTH];
  beq_pkg::hist_entry_t rd_q;
  logic                 rd_vld_q;
  logic [beq_pkg::HIST_DEPTH-1:0] valid_q;

  // storage array and read register
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  // per-entry written flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.rd_addr];
      end
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

@@ design/three_band_biquad_equalizer.sv @@
// ----------------------------------------------------------------------------
// three_band_biquad_equalizer: cascade of three direct-form-1 biquads
// Low shelf, peaking and high shelf sections share one multiplier; the
// per-channel history lives in a small synchronous memory.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   in_item_i  (channel, sample)
//   out       output     out_valid_o/out_ready_i out_item_o (channel, sample, clip)
//   cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// An item is accepted, then passes the multiply steps B1, B2, A1, A2 and B0 and
// a write-back step for each of the three sections, then the load of the output
// register; only then can the next item be taken. The single shared 21x32
// multiplier is why the items cannot overlap.
// Reset restores unity coefficients and clears all history at once.
// A stalled result waits in the output register; a new item is accepted
// meanwhile, and its result waits in the last cycle until the register frees.
// ----------------------------------------------------------------------------
module three_band_biquad_equalizer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  beq_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output beq_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [beq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [beq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_WRITE, S_OUT} state_e;
  typedef enum logic [2:0] {TAP_B1, TAP_B2, TAP_A1, TAP_A2, TAP_B0} tap_e;

  localparam int CW = beq_pkg::COEF_WIDTH;

  state_e state_q;
  tap_e   step_q;
  logic [beq_pkg::BAND_W-1:0] band_q;
  logic [beq_pkg::SLOT_W-1:0] slot_q;
  logic [beq_pkg::CHAN_W-1:0] chan_q;
  logic                       clip_q;
  logic                       out_valid_q;
  beq_pkg::out_item_t         out_q;

  logic [beq_pkg::FWD_W-1:0] fwd_q [beq_pkg::NUM_BANDS];
  logic [beq_pkg::FB_W-1:0]  fb_q  [beq_pkg::NUM_BANDS];

  logic signed [beq_pkg::HIST_W-1:0] x_q;
  logic signed [beq_pkg::PROD_W-1:0] prod_q;
  logic                              prod_sub_q;
  logic signed [beq_pkg::ACC_W-1:0]  acc_q;

  logic                       accept;
  logic                       last_band;
  logic [beq_pkg::SLOT_W-1:0] in_slot;
  logic [beq_pkg::BAND_W-1:0] band_next;
  beq_pkg::hist_req_t         hist_req;
  beq_pkg::hist_entry_t       hist_rd;
  beq_pkg::hist_entry_t       hist_wr;

  logic [beq_pkg::FWD_W-1:0]         fwd_sel;
  logic [beq_pkg::FB_W-1:0]          fb_sel;
  logic signed [CW-1:0]              coef_sel;
  logic signed [beq_pkg::HIST_W-1:0] opnd_sel;
  logic                              tap_sub;
  logic signed [beq_pkg::PROD_W-1:0] prod_d;
  logic signed [beq_pkg::ACC_W-1:0]  acc_next;
  logic signed [beq_pkg::ACC_W-1:0]  acc_rnd;
  logic signed [beq_pkg::ACC_W-1:0]  acc_shr;
  logic signed [beq_pkg::HIST_W-1:0] y_sat;
  logic                              sec_clip;
  logic signed [beq_pkg::SAMPLE_WIDTH-1:0] out_sat;
  logic                              out_clip;
  logic                              out_free;

  // history entry address of a band and channel slot
  function automatic logic [beq_pkg::HIST_AW-1:0] hist_addr(
    logic [beq_pkg::BAND_W-1:0] band,
    logic [beq_pkg::SLOT_W-1:0] slot
  );
    return (beq_pkg::HIST_AW)'(band) * (beq_pkg::HIST_AW)'(beq_pkg::NUM_CHANNELS)
           + (beq_pkg::HIST_AW)'(slot);
  endfunction

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign last_band = (band_q == (beq_pkg::BAND_W)'(beq_pkg::NUM_BANDS - 1));
  assign band_next = band_q + 1'b1;
  assign out_free  = !out_valid_q || out_ready_i;

  // channels above the last slot share its history
  assign in_slot = ({1'b0, in_item_i.channel} < (beq_pkg::CHAN_W + 1)'(beq_pkg::NUM_CHANNELS))
                 ? (beq_pkg::SLOT_W)'(in_item_i.channel)
                 : (beq_pkg::SLOT_W)'(beq_pkg::NUM_CHANNELS - 1);

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < beq_pkg::NUM_BANDS; b++) begin
        fwd_q[b] <= (beq_pkg::FWD_W)'(1) << beq_pkg::COEF_FRAC;
        fb_q[b]  <= '0;
      end
    end else if (cfg_we_i) begin
      for (int b = 0; b < beq_pkg::NUM_BANDS; b++) begin
        if (cfg_index_i == (beq_pkg::CFG_IDX_W)'(2 * b)) begin
          fwd_q[b] <= cfg_data_i[beq_pkg::FWD_W-1:0];
        end
        if (cfg_index_i == (beq_pkg::CFG_IDX_W)'(2 * b + 1)) begin
          fb_q[b] <= cfg_data_i[beq_pkg::FB_W-1:0];
        end
      end
    end
  end

  // history memory requests: read band 0 on accept, prefetch next band while writing this one back
  always_comb begin
    hist_req.rd_en   = accept || (state_q == S_WRITE && !last_band);
    hist_req.rd_addr = accept ? hist_addr('0, in_slot) : hist_addr(band_next, slot_q);
    hist_req.wr_en   = (state_q == S_WRITE);
    hist_req.wr_addr = hist_addr(band_q, slot_q);
  end

  beq_hist_mem u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (hist_req),
    .wr_data_i (hist_wr),
    .rd_data_o (hist_rd)
  );

  // tap selection for the shared multiplier
  assign fwd_sel = fwd_q[band_q];
  assign fb_sel  = fb_q[band_q];

  always_comb begin
    coef_sel = fwd_sel[CW-1:0];
    opnd_sel = x_q;
    tap_sub  = 1'b0;
    unique case (step_q)
      TAP_B1: begin
        coef_sel = fwd_sel[CW +: CW];
        opnd_sel = hist_rd.x1;
      end
      TAP_B2: begin
        coef_sel = fwd_sel[2*CW +: CW];
        opnd_sel = hist_rd.x2;
      end
      TAP_A1: begin
        coef_sel = fb_sel[CW-1:0];
        opnd_sel = hist_rd.y1;
        tap_sub  = 1'b1;
      end
      TAP_A2: begin
        coef_sel = fb_sel[CW +: CW];
        opnd_sel = hist_rd.y2;
        tap_sub  = 1'b1;
      end
      TAP_B0: begin
        coef_sel = fwd_sel[CW-1:0];
        opnd_sel = x_q;
      end
      default: begin
        coef_sel = '0;
        opnd_sel = '0;
      end
    endcase
  end

  assign prod_d   = coef_sel * opnd_sel;
  assign acc_next = prod_sub_q ? acc_q - (beq_pkg::ACC_W)'(prod_q)
                               : acc_q + (beq_pkg::ACC_W)'(prod_q);

  // round half up, floor shift, saturate to the history width
  always_comb begin
    acc_rnd  = acc_next + ((beq_pkg::ACC_W)'(1) <<< (beq_pkg::COEF_FRAC - 1));
    acc_shr  = acc_rnd >>> beq_pkg::COEF_FRAC;
    sec_clip = !((&acc_shr[beq_pkg::ACC_W-1:beq_pkg::HIST_W-1])
              || !(|acc_shr[beq_pkg::ACC_W-1:beq_pkg::HIST_W-1]));
    if (!sec_clip) begin
      y_sat = acc_shr[beq_pkg::HIST_W-1:0];
    end else if (acc_shr[beq_pkg::ACC_W-1]) begin
      y_sat = {1'b1, {(beq_pkg::HIST_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(beq_pkg::HIST_W-1){1'b1}}};
    end
  end

  // shifted history written back
  always_comb begin
    hist_wr.x1 = x_q;
    hist_wr.x2 = hist_rd.x1;
    hist_wr.y1 = y_sat;
    hist_wr.y2 = hist_rd.y1;
  end

  // final saturation to the sample width
  always_comb begin
    out_clip = !((&x_q[beq_pkg::HIST_W-1:beq_pkg::SAMPLE_WIDTH-1])
              || !(|x_q[beq_pkg::HIST_W-1:beq_pkg::SAMPLE_WIDTH-1]));
    if (!out_clip) begin
      out_sat = x_q[beq_pkg::SAMPLE_WIDTH-1:0];
    end else if (x_q[beq_pkg::HIST_W-1]) begin
      out_sat = {1'b1, {(beq_pkg::SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(beq_pkg::SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      chan_q <= in_item_i.channel;
      slot_q <= in_slot;
      x_q    <= (beq_pkg::HIST_W)'(in_item_i.sample);
    end
    if (state_q == S_MAC) begin
      prod_q     <= prod_d;
      prod_sub_q <= tap_sub;
      acc_q      <= (step_q == TAP_B1) ? '0 : acc_next;
    end
    if (state_q == S_WRITE) begin
      x_q <= y_sat;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= TAP_B1;
      band_q      <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // drained result, unless the load below refills the register
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_MAC;
            step_q  <= TAP_B1;
            band_q  <= '0;
            clip_q  <= 1'b0;
          end
        end
        S_MAC: begin
          unique case (step_q)
            TAP_B1:  step_q <= TAP_B2;
            TAP_B2:  step_q <= TAP_A1;
            TAP_A1:  step_q <= TAP_A2;
            TAP_A2:  step_q <= TAP_B0;
            TAP_B0:  state_q <= S_WRITE;
            default: step_q <= TAP_B1;
          endcase
        end
        S_WRITE: begin
          clip_q <= clip_q | sec_clip;
          if (last_band) begin
            state_q <= S_OUT;
          end else begin
            band_q  <= band_next;
            step_q  <= TAP_B1;
            state_q <= S_MAC;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_q.out_channel <= chan_q;
            out_q.out_sample  <= out_sat;
            out_q.clipped     <= clip_q | out_clip;
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  // the prefetch never hits the entry being written back
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hist_req.rd_en && hist_req.wr_en) |-> (hist_req.rd_addr != hist_req.wr_addr))
    else $error("history read and write on the same entry");

  // a result appears only after the output load cycle
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_OUT))
    else $error("result shown without a finished item");

  // write-back only for an existing band
  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (band_q <= (beq_pkg::BAND_W)'(beq_pkg::NUM_BANDS - 1)))
    else $error("band counter out of range");
`endif

endmodule
